@@ design/gcts_pkg.sv @@
// shared constants and types for the cost-to-goal search block
package gcts_pkg;

  localparam int MAX_NODES = 64;
  localparam int MAX_EDGES = 128;
  localparam int COST_BITS = 20;
  localparam int NODE_BITS = $clog2(MAX_NODES);
  localparam int CNT_BITS  = NODE_BITS + 1;
  localparam int EDGE_BITS = $clog2(MAX_EDGES);
  localparam int FILL_BITS = EDGE_BITS + 1;
  localparam int EDGE_W    = 2 * NODE_BITS + COST_BITS;
  localparam int NODE_W    = COST_BITS + NODE_BITS;

  localparam logic REG_GOAL  = 1'b0;
  localparam logic REG_COUNT = 1'b1;

  typedef logic [NODE_BITS-1:0] node_t;
  typedef logic [COST_BITS-1:0] cost_t;

  typedef struct packed {
    node_t a;
    node_t b;
    cost_t cost;
  } edge_t;

  typedef struct packed {
    cost_t cost;
    node_t toward;
  } label_t;

endpackage

@@ design/graph_cost_to_goal_search.sv @@
// top level: edge store, node labels and frontier queues for the cost-to-goal search
//
//  channel   handshake                 payload
//  edge in   start / busy              node_a, node_b, edge_cost, last_edge
//  config    cfg_write                 cfg_index, cfg_data
//  result    result_valid (strobe)     node_index, cost_to_goal, next_hop, reachable, last_node
//
// during an edge load busy stays high while the duplicate scan reads one stored edge a cycle
// from the edge ram; a rejected edge leaves busy low unless last_edge starts the search.
// a search walks each frontier node (frontier read, label read) and, for every stored edge,
// does an edge read and a hit check plus a label update on a hit, then streams the results
// out of the label ram, one beat a cycle.
// rst is synchronous and clears control state, the edge fill and the config registers;
// the rams are not cleared: only written entries are read.
// results cannot be stalled; busy stays high until the last beat has been registered.
module graph_cost_to_goal_search (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [gcts_pkg::NODE_BITS-1:0] node_a,
  input  logic [gcts_pkg::NODE_BITS-1:0] node_b,
  input  logic [gcts_pkg::COST_BITS-1:0] edge_cost,
  input  logic                        last_edge,
  input  logic                        cfg_write,
  input  logic                        cfg_index,
  input  logic [gcts_pkg::CNT_BITS-1:0]  cfg_data,
  output logic                        result_valid,
  output logic [gcts_pkg::NODE_BITS-1:0] node_index,
  output logic [gcts_pkg::COST_BITS-1:0] cost_to_goal,
  output logic [gcts_pkg::NODE_BITS-1:0] next_hop,
  output logic                        reachable,
  output logic                        last_node
);
  import gcts_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1;
  localparam logic [3:0] S_STORE = 4'd2;
  localparam logic [3:0] S_START = 4'd3;
  localparam logic [3:0] S_LEVEL = 4'd4;
  localparam logic [3:0] S_FRD   = 4'd5;
  localparam logic [3:0] S_FWAIT = 4'd6;
  localparam logic [3:0] S_UWAIT = 4'd7;
  localparam logic [3:0] S_EISS  = 4'd8;
  localparam logic [3:0] S_ECHK  = 4'd9;
  localparam logic [3:0] S_EUPD  = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  logic [3:0] state;

  // config registers
  node_t                goal_node;
  logic [CNT_BITS-1:0]  node_count;
  logic [CNT_BITS-1:0]  n_act;

  // load beat held while scanning
  edge_t                in_edge;
  logic                 in_last;
  logic [FILL_BITS-1:0] fill;
  logic [FILL_BITS-1:0] e_idx;
  logic                 pend;

  // search registers
  logic [MAX_NODES-1:0] seen;
  logic [MAX_NODES-1:0] queued;
  logic                 sel;       // 0: frontier ram a holds the current level
  logic [CNT_BITS-1:0]  now_len;
  logic [CNT_BITS-1:0]  next_len;
  logic [CNT_BITS-1:0]  k_idx;
  node_t                u_node;
  cost_t                u_cost;
  node_t                v_node;
  cost_t                v_sum;
  logic [CNT_BITS-1:0]  out_idx;
  node_t                idx_d;

  // ram ports
  edge_t                e_rdata;
  label_t               l_rdata;
  label_t               l_wdata;
  node_t                l_raddr;
  node_t                l_waddr;
  logic                 l_we;
  node_t                fa_rdata, fb_rdata, f_rdata;
  logic                 fa_we, fb_we;
  node_t                f_waddr, f_wdata;

  // edge decode for relaxation
  logic                 e_hit;
  node_t                e_other;
  logic [COST_BITS:0]   sum_wide;
  cost_t                sum_sat;
  logic                 improve;
  logic                 dup;
  logic                 in_bad;

  assign n_act = (node_count > CNT_BITS'(MAX_NODES)) ? CNT_BITS'(MAX_NODES) : node_count;
  assign busy  = (state != S_IDLE);
  assign f_rdata = sel ? fb_rdata : fa_rdata;

  assign in_bad = ({1'b0, node_a} >= n_act) || ({1'b0, node_b} >= n_act) ||
                  (fill == FILL_BITS'(MAX_EDGES));
  assign dup = ((e_rdata.a == in_edge.a) && (e_rdata.b == in_edge.b)) ||
               ((e_rdata.a == in_edge.b) && (e_rdata.b == in_edge.a));

  assign e_hit = ({1'b0, e_rdata.a} < n_act) && ({1'b0, e_rdata.b} < n_act) &&
                 ((e_rdata.a == u_node) || (e_rdata.b == u_node));
  assign e_other  = (e_rdata.a == u_node) ? e_rdata.b : e_rdata.a;
  assign sum_wide = {1'b0, u_cost} + {1'b0, e_rdata.cost};
  assign sum_sat  = sum_wide[COST_BITS] ? {COST_BITS{1'b1}} : sum_wide[COST_BITS-1:0];
  assign improve  = !seen[v_node] || (v_sum < l_rdata.cost);

  // label ram addressing
  always_comb begin
    l_raddr = out_idx[NODE_BITS-1:0];
    if (state == S_FWAIT) l_raddr = f_rdata;
    else if (state == S_ECHK) l_raddr = e_other;
    l_we    = 1'b0;
    l_waddr = v_node;
    l_wdata = '{cost: v_sum, toward: u_node};
    if (state == S_START) begin
      l_we    = ({1'b0, goal_node} < n_act);
      l_waddr = goal_node;
      l_wdata = '{cost: '0, toward: goal_node};
    end else if (state == S_EUPD) begin
      l_we = improve;
    end
  end

  // frontier push: goal seeds the current ram, improvements go to the other one
  logic push_next;
  logic seed_now;
  assign seed_now  = (state == S_START) && ({1'b0, goal_node} < n_act);
  assign push_next = (state == S_EUPD) && improve && !queued[v_node] &&
                     (next_len < CNT_BITS'(MAX_NODES));
  assign f_waddr = seed_now ? '0 : next_len[NODE_BITS-1:0];
  assign f_wdata = seed_now ? goal_node : v_node;
  assign fa_we   = (seed_now && !sel) || (push_next && sel);
  assign fb_we   = (seed_now && sel) || (push_next && !sel);

  gcts_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edges (
    .clk   (clk),
    .we    (state == S_STORE),
    .waddr (fill[EDGE_BITS-1:0]),
    .wdata (in_edge),
    .raddr (e_idx[EDGE_BITS-1:0]),
    .rdata (e_rdata)
  );

  gcts_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_labels (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

  gcts_ram #(.WIDTH(NODE_BITS), .DEPTH(MAX_NODES)) u_front_a (
    .clk   (clk),
    .we    (fa_we),
    .waddr (f_waddr),
    .wdata (f_wdata),
    .raddr (k_idx[NODE_BITS-1:0]),
    .rdata (fa_rdata)
  );

  gcts_ram #(.WIDTH(NODE_BITS), .DEPTH(MAX_NODES)) u_front_b (
    .clk   (clk),
    .we    (fb_we),
    .waddr (f_waddr),
    .wdata (f_wdata),
    .raddr (k_idx[NODE_BITS-1:0]),
    .rdata (fb_rdata)
  );

  // config port
  always_ff @(posedge clk) begin
    if (rst) begin
      goal_node  <= '0;
      node_count <= CNT_BITS'(MAX_NODES);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_GOAL:  goal_node  <= cfg_data[NODE_BITS-1:0];
        REG_COUNT: node_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      in_edge <= '{a: node_a, b: node_b, cost: edge_cost};
      in_last <= last_edge;
    end
    if (state == S_FWAIT) u_node <= f_rdata;
    if (state == S_UWAIT) u_cost <= l_rdata.cost;
    if (state == S_ECHK) begin
      v_node <= e_other;
      v_sum  <= sum_sat;
    end
    if (state == S_OUT) idx_d <= out_idx[NODE_BITS-1:0];
    node_index   <= idx_d;
    reachable    <= seen[idx_d];
    cost_to_goal <= seen[idx_d] ? l_rdata.cost : '0;
    next_hop     <= seen[idx_d] ? l_rdata.toward : idx_d;
    last_node    <= ({1'b0, idx_d} + CNT_BITS'(1)) == n_act;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      fill         <= '0;
      e_idx        <= '0;
      pend         <= 1'b0;
      seen         <= '0;
      queued       <= '0;
      sel          <= 1'b0;
      now_len      <= '0;
      next_len     <= '0;
      k_idx        <= '0;
      out_idx      <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= (state == S_OUT) && pend;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            e_idx <= '0;
            pend  <= 1'b0;
            if (in_bad) state <= last_edge ? S_START : S_IDLE;
            else        state <= S_SCAN;
          end
        end
        S_SCAN: begin
          pend <= (e_idx < fill);
          if (e_idx < fill) e_idx <= e_idx + FILL_BITS'(1);
          if (pend && dup)              state <= in_last ? S_START : S_IDLE;
          else if (!(e_idx < fill) && !pend) state <= S_STORE;
        end
        S_STORE: begin
          fill  <= fill + FILL_BITS'(1);
          state <= in_last ? S_START : S_IDLE;
        end
        S_START: begin
          out_idx <= '0;
          pend    <= 1'b0;
          if ({1'b0, goal_node} < n_act) begin
            // only the goal starts out labeled
            seen    <= MAX_NODES'(1) << goal_node;
            now_len <= CNT_BITS'(1);
            state   <= S_LEVEL;
          end else begin
            seen  <= '0;
            state <= S_OUT;
          end
        end
        S_LEVEL: begin
          queued   <= '0;
          next_len <= '0;
          k_idx    <= '0;
          state    <= S_FRD;
        end
        S_FRD: begin
          if (k_idx == now_len) begin
            if (next_len == '0) begin
              out_idx <= '0;
              pend    <= 1'b0;
              state   <= S_OUT;
            end else begin
              sel     <= !sel;
              now_len <= next_len;
              state   <= S_LEVEL;
            end
          end else begin
            state <= S_FWAIT;
          end
        end
        S_FWAIT: state <= S_UWAIT;
        S_UWAIT: begin
          e_idx <= '0;
          state <= S_EISS;
        end
        S_EISS: begin
          if (e_idx == fill) begin
            k_idx <= k_idx + CNT_BITS'(1);
            state <= S_FRD;
          end else begin
            state <= S_ECHK;
          end
        end
        S_ECHK: begin
          if (e_hit) begin
            state <= S_EUPD;
          end else begin
            e_idx <= e_idx + FILL_BITS'(1);
            state <= S_EISS;
          end
        end
        S_EUPD: begin
          if (improve) seen[v_node] <= 1'b1;
          if (push_next) begin
            queued[v_node] <= 1'b1;
            next_len       <= next_len + CNT_BITS'(1);
          end
          e_idx <= e_idx + FILL_BITS'(1);
          state <= S_EISS;
        end
        S_OUT: begin
          pend <= (out_idx < n_act);
          if (out_idx < n_act) out_idx <= out_idx + CNT_BITS'(1);
          if (!(out_idx < n_act) && !pend) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a result beat only follows a cycle spent in the output sweep
  a_result_from_sweep: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state) == S_OUT)
    else $error("result beat outside output sweep");

  // an update is always preceded by the edge check that named its node
  a_update_after_check: assert property (@(posedge clk) disable iff (rst)
    (state == S_EUPD) |-> $past(state) == S_ECHK)
    else $error("label update without edge check");

  // the edge store never overfills
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_STORE) |-> fill < FILL_BITS'(MAX_EDGES))
    else $error("edge store overfilled");

endmodule

@@ design/gcts_ram.sv @@
// generic single-write, single-read ram with registered read
module gcts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
